// ===== design/ewr_pkg.sv =====
package ewr_pkg;

   localparam int ZW = 40;  // residual angle, Q32
   localparam int XW = 44;  // CORDIC x/y, Q40 with headroom

   localparam logic signed [ZW-1:0] TWO_PI       = 40'sd26986075409;
   localparam logic signed [ZW-1:0] PI           = 40'sd13493037705;
   localparam logic signed [ZW-1:0] HALF_PI      = 40'sd6746518852;
   localparam logic signed [ZW-1:0] QUARTER_PI   = 40'sd3373259426;
   localparam logic signed [XW-1:0] CORDIC_GAIN  = 44'sd667681663043;
   localparam logic signed [31:0]   ONE_Q30      = 32'sd1073741824;

   typedef struct packed {
      logic signed [ZW-1:0] zx;
      logic signed [ZW-1:0] zy;
      logic signed [ZW-1:0] zz;
      logic [2:0]           flip;
      logic signed [31:0]   pos_x;
      logic signed [31:0]   pos_y;
      logic signed [31:0]   pos_z;
   } front_item_type;

   typedef struct packed {
      logic signed [31:0] r00;
      logic signed [31:0] r01;
      logic signed [31:0] r02;
      logic signed [31:0] r10;
      logic signed [31:0] r11;
      logic signed [31:0] r12;
      logic signed [31:0] r20;
      logic signed [31:0] r21;
      logic signed [31:0] r22;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
   } rsp_item_type;

   // atan(2^-i) in Q32: arctangent series in Q62, truncating terms, rounded half up
   function automatic logic signed [ZW-1:0] atan_q32(input int i);
      logic [63:0] sum;
      logic [63:0] term;
      int e;
      sum = '0;
      if (i == 0) begin
         return QUARTER_PI;
      end
      for (int k = 0; k < 64; k++) begin
         e = 62 - i * (2 * k + 1);
         if (e >= 0) begin
            term = (64'd1 << e) / 64'(2 * k + 1);
            if ((k % 2) == 0) begin
               sum = sum + term;
            end else begin
               sum = sum - term;
            end
         end
      end
      return ZW'((sum + (64'd1 << 29)) >> 30);
   endfunction

   // Q60 to Q30, round half up, clamp to +-1
   function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] v);
      logic signed [65:0] t;
      t = (v + 66'sd536870912) >>> 30;
      if (t > 66'sd1073741824) begin
         return ONE_Q30;
      end else if (t < -66'sd1073741824) begin
         return -ONE_Q30;
      end
      return t[31:0];
   endfunction

endpackage

// ===== design/ewr_fifo.sv =====
module ewr_fifo #(
   parameter type DATA_TYPE = logic,
   parameter int  DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  DATA_TYPE wdata,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output DATA_TYPE rdata
);

   localparam int AW = $clog2(DEPTH);

   DATA_TYPE          mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH)) else $error("queue count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && do_pop) |=> $stable(count_ff)) else $error("count moved on push+pop");

endmodule

// ===== design/ewr_front.sv =====
module ewr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic signed [31:0]      angle_x,
   input  logic signed [31:0]      angle_y,
   input  logic signed [31:0]      angle_z,
   input  logic signed [31:0]      pos_x,
   input  logic signed [31:0]      pos_y,
   input  logic signed [31:0]      pos_z,
   output logic                    mid_push,
   output ewr_pkg::front_item_type mid_data,
   input  logic                    mid_full
);

   logic                    vld_ff, vld_in;
   ewr_pkg::front_item_type item_ff, item_in;
   logic                    hold;
   logic [ewr_pkg::ZW:0]    rx, ry, rz;

   // wrap into [-pi, pi], then fold into [-pi/2, pi/2]; msb is the fold flag
   function automatic logic [ewr_pkg::ZW:0] reduce(input logic signed [31:0] a);
      logic signed [ewr_pkg::ZW-1:0] z;
      logic                          flip;
      z    = {{4{a[31]}}, a, 4'b0000};
      flip = 1'b0;
      if (z > ewr_pkg::PI) begin
         z = z - ewr_pkg::TWO_PI;
      end else if (z < -ewr_pkg::PI) begin
         z = z + ewr_pkg::TWO_PI;
      end
      if (z > ewr_pkg::HALF_PI) begin
         z    = z - ewr_pkg::PI;
         flip = 1'b1;
      end else if (z < -ewr_pkg::HALF_PI) begin
         z    = z + ewr_pkg::PI;
         flip = 1'b1;
      end
      return {flip, z};
   endfunction

   assign hold     = vld_ff && mid_full;
   assign full     = hold;
   assign mid_push = vld_ff && !mid_full;
   assign mid_data = item_ff;

   assign rx = reduce(angle_x);
   assign ry = reduce(angle_y);
   assign rz = reduce(angle_z);

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (!hold) begin
         vld_in        = push;
         item_in.zx    = rx[ewr_pkg::ZW-1:0];
         item_in.zy    = ry[ewr_pkg::ZW-1:0];
         item_in.zz    = rz[ewr_pkg::ZW-1:0];
         item_in.flip  = {rz[ewr_pkg::ZW], ry[ewr_pkg::ZW], rx[ewr_pkg::ZW]};
         item_in.pos_x = pos_x;
         item_in.pos_y = pos_y;
         item_in.pos_z = pos_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== design/ewr_cordic.sv =====
module ewr_cordic #(
   parameter int STEPS = 24
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [ewr_pkg::ZW-1:0]  z_in,
   input  logic                           flip_in,
   output logic signed [31:0]             sin_out,
   output logic signed [31:0]             cos_out
);

   localparam int XW = ewr_pkg::XW;
   localparam int ZW = ewr_pkg::ZW;

   logic signed [XW-1:0] x_ff [STEPS+1];
   logic signed [XW-1:0] y_ff [STEPS+1];
   logic signed [ZW-1:0] z_ff [STEPS+1];
   logic                 f_ff [STEPS+1];
   logic signed [31:0]   sin_ff, cos_ff;

   // load stage
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= ewr_pkg::CORDIC_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= z_in;
         f_ff[0] <= flip_in;
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ZW-1:0] ATAN = ewr_pkg::atan_q32(i);
      logic signed [XW-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            f_ff[i+1] <= f_ff[i];
         end
      end
   end

   // Q40 to Q30 with rounding, clamp, fold sign
   function automatic logic signed [31:0] to_q30(input logic signed [XW-1:0] v,
                                                 input logic flip);
      logic signed [XW-1:0] t;
      logic signed [31:0]   r;
      t = (v + XW'(512)) >>> 10;
      if (t > XW'(1073741824)) begin
         r = ewr_pkg::ONE_Q30;
      end else if (t < -XW'(1073741824)) begin
         r = -ewr_pkg::ONE_Q30;
      end else begin
         r = t[31:0];
      end
      return flip ? -r : r;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= to_q30(y_ff[STEPS], f_ff[STEPS]);
         cos_ff <= to_q30(x_ff[STEPS], f_ff[STEPS]);
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ===== design/ewr_back.sv =====
module ewr_back #(
   parameter int STEPS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  ewr_pkg::front_item_type in_data,
   output logic                    in_pop,
   input  logic                    out_full,
   output logic                    out_push,
   output ewr_pkg::rsp_item_type   out_data
);

   // CORDIC load + steps + rounding, then four product stages
   localparam int LAT = STEPS + 6;

   logic               adv;
   logic               vld_ff [LAT];
   logic [95:0]        pos_ff [LAT];
   logic signed [31:0] sx, cx, sy, cy, sz, cz;

   // stage 1: direct products
   logic signed [63:0] sxsy1, cxsy1, cycz1, cysz1, sxcy1, cxcy1, cxsz1, cxcz1, sxsz1, sxcz1;
   logic signed [31:0] sy1, cz1, sz1;
   // stage 2: shared terms rounded
   logic signed [31:0] p2, q2, sy2, cz2, sz2;
   logic signed [63:0] cycz2, cysz2, sxcy2, cxcy2, cxsz2, cxcz2, sxsz2, sxcz2;
   // stage 3: products of shared terms
   logic signed [63:0] pcz3, psz3, qcz3, qsz3;
   logic signed [63:0] cycz3, cysz3, sxcy3, cxcy3, cxsz3, cxcz3, sxsz3, sxcz3;
   logic signed [31:0] sy3;
   ewr_pkg::rsp_item_type res_ff;

   assign adv      = !out_full;
   assign in_pop   = adv && in_valid;
   assign out_push = adv && vld_ff[LAT-1];
   assign out_data = res_ff;

   ewr_cordic #(.STEPS(STEPS)) u_cx (.clock(clock), .en(adv), .z_in(in_data.zx),
      .flip_in(in_data.flip[0]), .sin_out(sx), .cos_out(cx));
   ewr_cordic #(.STEPS(STEPS)) u_cy (.clock(clock), .en(adv), .z_in(in_data.zy),
      .flip_in(in_data.flip[1]), .sin_out(sy), .cos_out(cy));
   ewr_cordic #(.STEPS(STEPS)) u_cz (.clock(clock), .en(adv), .z_in(in_data.zz),
      .flip_in(in_data.flip[2]), .sin_out(sz), .cos_out(cz));

   // valid and position delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff[0] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
         for (int i = 1; i < LAT; i++) begin
            pos_ff[i] <= pos_ff[i-1];
         end
      end
   end

   // matrix product pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         sxsy1 <= sx * sy;  cxsy1 <= cx * sy;
         cycz1 <= cy * cz;  cysz1 <= cy * sz;
         sxcy1 <= sx * cy;  cxcy1 <= cx * cy;
         cxsz1 <= cx * sz;  cxcz1 <= cx * cz;
         sxsz1 <= sx * sz;  sxcz1 <= sx * cz;
         sy1 <= sy;  cz1 <= cz;  sz1 <= sz;

         p2 <= ewr_pkg::rnd_sat(66'(sxsy1));
         q2 <= ewr_pkg::rnd_sat(66'(cxsy1));
         cycz2 <= cycz1;  cysz2 <= cysz1;  sxcy2 <= sxcy1;  cxcy2 <= cxcy1;
         cxsz2 <= cxsz1;  cxcz2 <= cxcz1;  sxsz2 <= sxsz1;  sxcz2 <= sxcz1;
         sy2 <= sy1;  cz2 <= cz1;  sz2 <= sz1;

         pcz3 <= p2 * cz2;  psz3 <= p2 * sz2;
         qcz3 <= q2 * cz2;  qsz3 <= q2 * sz2;
         cycz3 <= cycz2;  cysz3 <= cysz2;  sxcy3 <= sxcy2;  cxcy3 <= cxcy2;
         cxsz3 <= cxsz2;  cxcz3 <= cxcz2;  sxsz3 <= sxsz2;  sxcz3 <= sxcz2;
         sy3 <= sy2;

         res_ff.r00 <= ewr_pkg::rnd_sat(66'(cycz3));
         res_ff.r01 <= ewr_pkg::rnd_sat(-66'(cysz3));
         res_ff.r02 <= sy3;
         res_ff.r10 <= ewr_pkg::rnd_sat(66'(pcz3) + 66'(cxsz3));
         res_ff.r11 <= ewr_pkg::rnd_sat(66'(cxcz3) - 66'(psz3));
         res_ff.r12 <= ewr_pkg::rnd_sat(-66'(sxcy3));
         res_ff.r20 <= ewr_pkg::rnd_sat(66'(sxsz3) - 66'(qcz3));
         res_ff.r21 <= ewr_pkg::rnd_sat(66'(qsz3) + 66'(sxcz3));
         res_ff.r22 <= ewr_pkg::rnd_sat(66'(cxcy3));
         {res_ff.trans_x, res_ff.trans_y, res_ff.trans_z} <= pos_ff[LAT-2];
      end
   end

endmodule

// ===== design/euler_xyz_to_rotation_matrix.sv =====
// Path from push to result: front register, queue, CORDIC load/steps/round,
// four product stages, output queue.
// Throughput: one pose per cycle; the pipelined CORDIC lanes and product
// stages each take a new pose every cycle and stall together on a full output.
// Reset: synchronous, active high; empties both queues and clears all valids.
module euler_xyz_to_rotation_matrix #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [31:0] req_angle_x,
   input  logic signed [31:0] req_angle_y,
   input  logic signed [31:0] req_angle_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_r00,
   output logic signed [31:0] rsp_r01,
   output logic signed [31:0] rsp_r02,
   output logic signed [31:0] rsp_r10,
   output logic signed [31:0] rsp_r11,
   output logic signed [31:0] rsp_r12,
   output logic signed [31:0] rsp_r20,
   output logic signed [31:0] rsp_r21,
   output logic signed [31:0] rsp_r22,
   output logic signed [31:0] rsp_trans_x,
   output logic signed [31:0] rsp_trans_y,
   output logic signed [31:0] rsp_trans_z
);

   localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

   logic                    mid_push, mid_full, mid_empty, mid_pop;
   ewr_pkg::front_item_type mid_wdata, mid_rdata;
   logic                    out_push, out_full;
   ewr_pkg::rsp_item_type   out_wdata, out_rdata;

   // angle reduction and fold
   ewr_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .angle_x(req_angle_x), .angle_y(req_angle_y), .angle_z(req_angle_z),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .mid_push(mid_push), .mid_data(mid_wdata), .mid_full(mid_full)
   );

   // decoupling queue between front and back
   ewr_fifo #(.DATA_TYPE(ewr_pkg::front_item_type), .DEPTH(4)) u_mid_q (
      .clock(clock), .reset(reset), .push(mid_push), .wdata(mid_wdata),
      .full(mid_full), .pop(mid_pop), .empty(mid_empty), .rdata(mid_rdata)
   );

   // CORDIC lanes and matrix products
   ewr_back #(.STEPS(STEPS)) u_back (
      .clock(clock), .reset(reset), .in_valid(!mid_empty), .in_data(mid_rdata),
      .in_pop(mid_pop), .out_full(out_full), .out_push(out_push), .out_data(out_wdata)
   );

   // result queue
   ewr_fifo #(.DATA_TYPE(ewr_pkg::rsp_item_type), .DEPTH(4)) u_out_q (
      .clock(clock), .reset(reset), .push(out_push), .wdata(out_wdata),
      .full(out_full), .pop(pop), .empty(empty), .rdata(out_rdata)
   );

   assign rsp_r00     = out_rdata.r00;
   assign rsp_r01     = out_rdata.r01;
   assign rsp_r02     = out_rdata.r02;
   assign rsp_r10     = out_rdata.r10;
   assign rsp_r11     = out_rdata.r11;
   assign rsp_r12     = out_rdata.r12;
   assign rsp_r20     = out_rdata.r20;
   assign rsp_r21     = out_rdata.r21;
   assign rsp_r22     = out_rdata.r22;
   assign rsp_trans_x = out_rdata.trans_x;
   assign rsp_trans_y = out_rdata.trans_y;
   assign rsp_trans_z = out_rdata.trans_z;

endmodule

// ===== verif/tb_euler_xyz_to_rotation_matrix.sv =====
module tb_euler_xyz_to_rotation_matrix;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = STEPS + 20;
   localparam int RANDOM_POSES = 600;

   // fixed Q4.28 angles used by the directed rows
   localparam logic signed [31:0] ANG_PI_HALF = 32'sd421657428;   // ~pi/2
   localparam logic signed [31:0] ANG_PI      = 32'sd843314857;   // ~pi
   localparam logic signed [31:0] ANG_MAX     = 32'sh7fffffff;
   localparam logic signed [31:0] ANG_MIN     = 32'sh80000000;

   typedef struct {
      logic signed [31:0] ax, ay, az, px, py, pz;
   } pose_type;

   typedef struct {
      pose_type              pose;
      bit                    typed;   // expected matrix given in the row
      ewr_pkg::rsp_item_type mat;
   } pose_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic signed [31:0] req_angle_x = '0, req_angle_y = '0, req_angle_z = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] rsp_r00, rsp_r01, rsp_r02, rsp_r10, rsp_r11, rsp_r12;
   logic signed [31:0] rsp_r20, rsp_r21, rsp_r22, rsp_trans_x, rsp_trans_y, rsp_trans_z;

   euler_xyz_to_rotation_matrix #(.CORDIC_STEPS(STEPS)) u_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   ewr_pkg::rsp_item_type matrix_queue[$];
   longint atan_lut[32];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int push_idle_pct = 0;
   int pop_idle_pct = 0;

   // ---------------- predictor ----------------
   function automatic longint fshr(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic longint rshr(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
   endfunction

   function automatic void fill_atan_lut();
      longint unsigned acc, term;
      int k, e;
      atan_lut[0] = 64'sd3373259426;
      for (int i = 1; i < 32; i++) begin
         acc = 0;
         k = 0;
         e = 62 - i;
         while (e >= 0) begin
            term = (64'd1 << e) / longint'(2 * k + 1);
            if (k % 2 == 0) acc += term; else acc -= term;
            k++;
            e = 62 - i * (2 * k + 1);
         end
         atan_lut[i] = longint'((acc + (64'd1 << 29)) >> 30);
      end
   endfunction

   task automatic angle_sin_cos(input logic signed [31:0] ang, output longint s,
                                output longint c);
      longint z, x, y, xs, ys;
      bit flip;
      z = longint'(ang) * 16;
      x = 64'sd667681663043;
      y = 0;
      flip = 0;
      if (z > 64'sd13493037705) z -= 64'sd26986075409;
      else if (z < -64'sd13493037705) z += 64'sd26986075409;
      if (z > 64'sd6746518852) begin
         z -= 64'sd13493037705;
         flip = 1;
      end else if (z < -64'sd6746518852) begin
         z += 64'sd13493037705;
         flip = 1;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
         xs = fshr(x, i);
         ys = fshr(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_lut[i];
         end else begin
            x += ys; y -= xs; z += atan_lut[i];
         end
      end
      s = clamp_unit(rshr(y, 10));
      c = clamp_unit(rshr(x, 10));
      if (flip) begin
         s = -s;
         c = -c;
      end
   endtask

   function automatic logic signed [31:0] q60_entry(longint v);
      return 32'(clamp_unit(rshr(v, 30)));
   endfunction

   task automatic pose_to_matrix(input pose_type p, output ewr_pkg::rsp_item_type m);
      longint sx, cx, sy, cy, sz, cz, ps, qs;
      angle_sin_cos(p.ax, sx, cx);
      angle_sin_cos(p.ay, sy, cy);
      angle_sin_cos(p.az, sz, cz);
      ps = rshr(sx * sy, 30);
      qs = rshr(cx * sy, 30);
      m.r00 = q60_entry(cy * cz);
      m.r01 = q60_entry(-(cy * sz));
      m.r02 = q60_entry(sy * 64'sd1073741824);
      m.r10 = q60_entry(ps * cz + cx * sz);
      m.r11 = q60_entry(cx * cz - ps * sz);
      m.r12 = q60_entry(-(sx * cy));
      m.r20 = q60_entry(sx * sz - qs * cz);
      m.r21 = q60_entry(qs * sz + sx * cz);
      m.r22 = q60_entry(cx * cy);
      m.trans_x = p.px;
      m.trans_y = p.py;
      m.trans_z = p.pz;
   endtask

   // ---------------- driving ----------------
   task automatic send_pose(input pose_type p);
      @(negedge clock);
      while (push_idle_pct > 0 && $urandom_range(99) < push_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_angle_x <= p.ax; req_angle_y <= p.ay; req_angle_z <= p.az;
      req_pos_x <= p.px; req_pos_y <= p.py; req_pos_z <= p.pz;
      do @(posedge clock); while (full);
   endtask

   task automatic push_row(input pose_row_type row);
      ewr_pkg::rsp_item_type m;
      if (row.typed) m = row.mat;
      else pose_to_matrix(row.pose, m);
      matrix_queue.push_back(m);
      send_pose(row.pose);
   endtask

   function automatic logic signed [31:0] rand_angle();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(1686629714))) - 32'sd843314857;
         2: return ($urandom_range(1)) ? ANG_MAX - $urandom_range(3) : ANG_MIN + $urandom_range(3);
         default: return 32'($signed($urandom_range(4000))) - 32'sd2000
                         + (($urandom_range(1)) ? ANG_PI_HALF : -ANG_PI_HALF);
      endcase
   endfunction

   // pop side and checking
   always @(negedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("euler_xyz_to_rotation_matrix: mismatch");
            $finish;
         end
         if (pop && !empty) begin
            ewr_pkg::rsp_item_type got, want;
            got = '{rsp_r00, rsp_r01, rsp_r02, rsp_r10, rsp_r11, rsp_r12,
                    rsp_r20, rsp_r21, rsp_r22, rsp_trans_x, rsp_trans_y, rsp_trans_z};
            if (matrix_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected transaction %p", got);
            end else begin
               want = matrix_queue.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) $display("expected %p\n  actual %p", want, got);
               end
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   initial begin
      pose_row_type rows[$];
      pose_row_type r;
      int drain;
      fill_atan_lut();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero pose (CORDIC residual leaves small off-diagonal terms); position extremes
      r.typed = 0;
      r.pose = '{0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0};
      rows.push_back(r);
      r.pose = '{ANG_MAX, ANG_MAX, ANG_MAX, -1, 1, 32'sh7fffffff}; rows.push_back(r);
      r.pose = '{ANG_MIN, ANG_MIN, ANG_MIN, 32'sh80000000, -1, 0}; rows.push_back(r);
      r.pose = '{ANG_PI, 0, 0, 5, 6, 7}; rows.push_back(r);
      r.pose = '{0, -ANG_PI, 0, 0, 0, 0}; rows.push_back(r);
      r.pose = '{0, 0, ANG_PI + 1, 0, 0, 0}; rows.push_back(r);
      r.pose = '{ANG_PI_HALF, 0, 0, 0, 0, 0}; rows.push_back(r);
      r.pose = '{0, ANG_PI_HALF, 0, 0, 0, 0}; rows.push_back(r);
      r.pose = '{0, -ANG_PI_HALF, 0, 0, 0, 0}; rows.push_back(r);
      r.pose = '{0, 0, ANG_PI_HALF + 1, 0, 0, 0}; rows.push_back(r);
      r.pose = '{-ANG_PI_HALF - 1, ANG_PI_HALF, -ANG_PI_HALF, 1, 2, 3}; rows.push_back(r);
      r.pose = '{ANG_PI, ANG_PI, ANG_PI, 0, 0, 0}; rows.push_back(r);
      r.pose = '{1, -1, 1, 0, 0, 0}; rows.push_back(r);
      r.pose = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678,
                 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F}; rows.push_back(r);
      foreach (rows[i]) push_row(rows[i]);

      // three phases of random poses; the first two idle push and pop, the last does not
      for (int ph = 0; ph < 3; ph++) begin
         push_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 84 : 0;
         pop_idle_pct  = (ph == 0) ? 84 : (ph == 1) ? 30 : 0;
         for (int n = 0; n < RANDOM_POSES / 3; n++) begin
            if (n == 100) begin
               // hold off until everything sent so far has come back
               @(negedge clock);
               push <= 1'b0;
               while (matrix_queue.size() != 0) @(posedge clock);
            end
            r.typed = 0;
            r.pose = '{rand_angle(), rand_angle(), rand_angle(), $urandom, $urandom, $urandom};
            push_row(r);
         end
      end
      @(negedge clock);
      push <= 1'b0;

      while (matrix_queue.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end
      if (mismatch_count == 0 && matrix_queue.size() == 0)
         $display("euler_xyz_to_rotation_matrix: match");
      else
         $display("euler_xyz_to_rotation_matrix: mismatch");
      $finish;
   end
endmodule

// ===== files.f =====
design/ewr_pkg.sv
design/ewr_fifo.sv
design/ewr_front.sv
design/ewr_cordic.sv
design/ewr_back.sv
design/euler_xyz_to_rotation_matrix.sv
verif/tb_euler_xyz_to_rotation_matrix.sv
